### hw/rtl/qsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsfd_pkg
// Shared constants, types and count helpers of the quadtree split flag decoder.
// ----------------------------------------------------------------------------
package qsfd_pkg;

    localparam int unsigned LEVELS        = 4;
    localparam int unsigned QIDX_W        = $clog2(LEVELS);
    localparam int unsigned NUM_PARTS_DEF = 256;
    localparam logic [2:0]  MAX_DEPTH_RST = 3'd3;
    localparam logic [1:0]  QUAD_LAST     = 2'd3;

    typedef struct packed {
        logic [7:0] start;
        logic [8:0] count;
        logic [2:0] depth;
        logic       done;
        logic       forced;
    } t_leaf;

    function automatic logic [31:0] count_full(input int unsigned num_parts,
                                               input logic [2:0] level);
        logic [31:0] parts;
        parts = 32'(num_parts);
        if (level > 3'(LEVELS)) begin
            return 32'd0;
        end
        return parts >> (2 * level);
    endfunction

    function automatic logic [8:0] count_at(input int unsigned num_parts,
                                            input logic [2:0] level);
        logic [31:0] full;
        full = count_full(num_parts, level);
        return full[8:0];
    endfunction

    // Deepest level whose partition count is still at least one.
    function automatic logic [2:0] max_eff_depth(input int unsigned num_parts);
        logic [2:0] d;
        d = 3'(LEVELS);
        for (int k = 0; k < LEVELS; k++) begin
            if (d != 3'd0 && count_full(num_parts, d) == 32'd0) begin
                d = d - 3'd1;
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/qsfd_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsfd_walker
// Quadtree walk state and the per-flag level, quadrant and position update.
// ----------------------------------------------------------------------------
module qsfd_walker #(
    parameter int unsigned NUM_PARTS = qsfd_pkg::NUM_PARTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic            i_split_flag,
    input  wire logic [2:0]      i_max_depth,
    output logic                 o_is_leaf,
    output qsfd_pkg::t_leaf      o_leaf
);

    localparam logic [2:0] MAX_EFF = qsfd_pkg::max_eff_depth(NUM_PARTS);
    localparam logic [2:0] LVL_MAX = 3'(qsfd_pkg::LEVELS);

    logic [2:0] r_cur_level, n_cur_level;
    logic [7:0] r_pos,       n_pos;
    logic [1:0] r_quad [qsfd_pkg::LEVELS];
    logic [1:0] n_quad [qsfd_pkg::LEVELS];

    logic [2:0] lvl;
    logic [2:0] md;
    logic [2:0] eff;
    logic [2:0] up;
    logic       do_split;
    logic [8:0] count;

    always_comb begin
        lvl      = (r_cur_level > LVL_MAX) ? LVL_MAX : r_cur_level;
        md       = (i_max_depth > LVL_MAX) ? LVL_MAX : i_max_depth;
        eff      = (md > MAX_EFF) ? MAX_EFF : md;
        do_split = i_split_flag && (lvl < eff);
        count    = qsfd_pkg::count_at(NUM_PARTS, lvl);

        up = lvl;
        for (int j = qsfd_pkg::LEVELS; j >= 1; j--) begin
            if (up == 3'(j) && r_quad[qsfd_pkg::QIDX_W'(j - 1)] == qsfd_pkg::QUAD_LAST) begin
                up = 3'(j - 1);
            end
        end

        o_is_leaf     = !do_split;
        o_leaf.start  = r_pos;
        o_leaf.count  = count;
        o_leaf.depth  = lvl;
        o_leaf.done   = (up == 3'd0);
        o_leaf.forced = i_split_flag;

        n_cur_level = r_cur_level;
        n_pos       = r_pos;
        n_quad      = r_quad;
        if (i_fire) begin
            if (do_split) begin
                n_quad[lvl[qsfd_pkg::QIDX_W-1:0]] = 2'd0;
                n_cur_level = lvl + 3'd1;
            end else if (up == 3'd0) begin
                n_cur_level = 3'd0;
                n_pos       = 8'd0;
                for (int k = 0; k < qsfd_pkg::LEVELS; k++) begin
                    n_quad[k] = 2'd0;
                end
            end else begin
                n_pos       = r_pos + count[7:0];
                n_cur_level = up;
                n_quad[qsfd_pkg::QIDX_W'(up - 3'd1)] =
                    r_quad[qsfd_pkg::QIDX_W'(up - 3'd1)] + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_level <= 3'd0;
            r_pos       <= 8'd0;
            for (int k = 0; k < qsfd_pkg::LEVELS; k++) begin
                r_quad[k] <= 2'd0;
            end
        end else begin
            r_cur_level <= n_cur_level;
            r_pos       <= n_pos;
            r_quad      <= n_quad;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/qsfd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsfd_out_reg
// Result register that holds one leaf transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module qsfd_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire qsfd_pkg::t_leaf i_leaf,
    input  wire logic            i_out_stall,
    output logic                 o_free,
    output logic                 o_out_valid,
    output qsfd_pkg::t_leaf      o_leaf
);

    logic            r_valid, n_valid;
    qsfd_pkg::t_leaf r_leaf;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_leaf      = r_leaf;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_leaf <= i_leaf;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/quadtree_split_flag_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_split_flag_decoder_core
// Turns depth-first split flags of a coding-tree block into leaf transactions.
//
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_split_flag
// output    out        o_out_valid / i_out_stall o_leaf_start, o_leaf_count,
//                                               o_leaf_depth, o_block_done,
//                                               o_forced_leaf
// config    in         i_cfg_we                 i_cfg_wdata (max_depth)
//
// One flag is taken per cycle while o_in_stall is low; a leaf passes the input
// register and then the result register before it is presented.
// The input register feeds the walk state update.
// Reset clears the walk to depth 0 and sets max_depth to 3.
// A stalled output blocks only flags that close a leaf; splits still advance.
// ----------------------------------------------------------------------------
module quadtree_split_flag_decoder_core #(
    parameter int unsigned NUM_PARTS = qsfd_pkg::NUM_PARTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_split_flag,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_leaf_start,
    output logic [8:0]      o_leaf_count,
    output logic [2:0]      o_leaf_depth,
    output logic            o_block_done,
    output logic            o_forced_leaf
);

    logic            r_in_valid, n_in_valid;
    logic            r_flag;
    logic [2:0]      r_max_depth;
    logic            accept;
    logic            fire;
    logic            is_leaf;
    logic            out_free;
    qsfd_pkg::t_leaf leaf;
    qsfd_pkg::t_leaf out_leaf;

    assign fire       = r_in_valid && (!is_leaf || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_max_depth <= qsfd_pkg::MAX_DEPTH_RST;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_max_depth <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag <= i_split_flag;
        end
    end

    qsfd_walker #(
        .NUM_PARTS(NUM_PARTS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_split_flag (r_flag),
        .i_max_depth  (r_max_depth),
        .o_is_leaf    (is_leaf),
        .o_leaf       (leaf)
    );

    qsfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && is_leaf),
        .i_leaf      (leaf),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_leaf      (out_leaf)
    );

    assign o_leaf_start  = out_leaf.start;
    assign o_leaf_count  = out_leaf.count;
    assign o_leaf_depth  = out_leaf.depth;
    assign o_block_done  = out_leaf.done;
    assign o_forced_leaf = out_leaf.forced;

endmodule
`default_nettype wire

### hw/rtl/qsfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsfd_checker
// Port-level assertions for the quadtree split flag decoder core.
// ----------------------------------------------------------------------------
module qsfd_checker #(
    parameter int unsigned NUM_PARTS = qsfd_pkg::NUM_PARTS_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_split_flag,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_leaf_start,
    input wire logic [8:0] o_leaf_count,
    input wire logic [2:0] o_leaf_depth,
    input wire logic       o_block_done,
    input wire logic       o_forced_leaf
);

    logic [7:0] r_expect_start;
    logic [8:0] exp_count;

    assign exp_count = qsfd_pkg::count_at(NUM_PARTS, o_leaf_depth);

    // Each leaf starts where the previous one ended; a finished block restarts at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_start <= 8'd0;
        end else if (o_out_valid && !i_out_stall) begin
            r_expect_start <= o_block_done ? 8'd0 : o_leaf_start + o_leaf_count[7:0];
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_split_flag))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_leaf_start)
            && $stable(o_leaf_count) && $stable(o_leaf_depth)
            && $stable(o_block_done) && $stable(o_forced_leaf))
        else $error("stalled output transaction changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("activity right after reset");

    a_start_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_leaf_start == r_expect_start)
        else $error("leaf start does not follow the previous leaf");

    a_count_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid || o_leaf_count == exp_count)
        else $error("leaf count does not match leaf depth");

endmodule

bind quadtree_split_flag_decoder_core qsfd_checker #(.NUM_PARTS(NUM_PARTS)) u_qsfd_checker (.*);
`default_nettype wire
